// ===== src/reflow_profile_sequencer_macros.svh =====
// Assertion helpers used by the sequencer control module.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef REFLOW_PROFILE_SEQUENCER_MACROS_SVH
`define REFLOW_PROFILE_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rps_pkg.sv =====
package rps_pkg;

  localparam int unsigned MS_PER_SECOND_DEF = 1000;
  localparam int unsigned STAMP_BITS_DEF    = 32;
  localparam int unsigned STAMP_W_MAX       = 64;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned TEMP_W  = 10;
  localparam int unsigned LVL_W   = 9;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned DELTA_W = TEMP_W + 1;
  localparam int unsigned MAG_W   = TEMP_W;
  localparam int unsigned PROD_W  = SEC_W + MAG_W;

  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [LVL_W-1:0]  PREHEAT_TARGET_RST = 9'd150;
  localparam logic [LVL_W-1:0]  SOAK_LEVEL_RST     = 9'd180;
  localparam logic [LVL_W-1:0]  PEAK_LEVEL_RST     = 9'd240;
  localparam logic [LVL_W-1:0]  COOL_LEVEL_RST     = 9'd25;
  localparam logic [SEC_W-1:0]  PREHEAT_END_RST    = 16'd90;
  localparam logic [SEC_W-1:0]  SOAK_END_RST       = 16'd150;
  localparam logic [SEC_W-1:0]  REFLOW_END_RST     = 16'd180;
  localparam logic [LVL_W-1:0]  WARM_THRESHOLD_RST = 9'd30;
  localparam logic [TEMP_W-1:0] TARGET_RST         = 10'd150;

  typedef enum logic [2:0] {
    REG_PREHEAT_TARGET = 3'd0,
    REG_SOAK_LEVEL     = 3'd1,
    REG_PEAK_LEVEL     = 3'd2,
    REG_COOL_LEVEL     = 3'd3,
    REG_PREHEAT_END    = 3'd4,
    REG_SOAK_END       = 3'd5,
    REG_REFLOW_END     = 3'd6,
    REG_WARM_THRESHOLD = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_PREHEAT = 3'd1,
    PH_SOAK    = 3'd2,
    PH_REFLOW  = 3'd3,
    PH_COOL    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_ELAPSED,
    ST_SELECT,
    ST_MUL,
    ST_DIV_RAMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [LVL_W-1:0] preheat_target;
    logic [LVL_W-1:0] soak_level;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] cool_level;
    logic [SEC_W-1:0] preheat_end_s;
    logic [SEC_W-1:0] soak_end_s;
    logic [SEC_W-1:0] reflow_end_s;
    logic [LVL_W-1:0] warm_threshold;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic latch_start;
    logic div_start;
    logic div_ramp;
    logic select;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sw_on;
    logic div_busy;
    logic is_ramp;
  } dp_status_t;

  typedef struct packed {
    logic             led_cool;
    logic             led_hot;
    logic             fan_on;
    logic             heater_enable;
    phase_e           phase;
    logic [TEMP_W-1:0] setpoint;
  } res_t;

endpackage

// ===== src/rps_regs.sv =====
module rps_regs
  import rps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PREHEAT_TARGET: cfg_d.preheat_target = pwdata[LVL_W-1:0];
        REG_SOAK_LEVEL:     cfg_d.soak_level     = pwdata[LVL_W-1:0];
        REG_PEAK_LEVEL:     cfg_d.peak_level     = pwdata[LVL_W-1:0];
        REG_COOL_LEVEL:     cfg_d.cool_level     = pwdata[LVL_W-1:0];
        REG_PREHEAT_END:    cfg_d.preheat_end_s  = pwdata[SEC_W-1:0];
        REG_SOAK_END:       cfg_d.soak_end_s     = pwdata[SEC_W-1:0];
        REG_REFLOW_END:     cfg_d.reflow_end_s   = pwdata[SEC_W-1:0];
        REG_WARM_THRESHOLD: cfg_d.warm_threshold = pwdata[LVL_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PREHEAT_TARGET: prdata = CFG_DW'(cfg_q.preheat_target);
      REG_SOAK_LEVEL:     prdata = CFG_DW'(cfg_q.soak_level);
      REG_PEAK_LEVEL:     prdata = CFG_DW'(cfg_q.peak_level);
      REG_COOL_LEVEL:     prdata = CFG_DW'(cfg_q.cool_level);
      REG_PREHEAT_END:    prdata = CFG_DW'(cfg_q.preheat_end_s);
      REG_SOAK_END:       prdata = CFG_DW'(cfg_q.soak_end_s);
      REG_REFLOW_END:     prdata = CFG_DW'(cfg_q.reflow_end_s);
      REG_WARM_THRESHOLD: prdata = CFG_DW'(cfg_q.warm_threshold);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preheat_target <= PREHEAT_TARGET_RST;
      cfg_q.soak_level     <= SOAK_LEVEL_RST;
      cfg_q.peak_level     <= PEAK_LEVEL_RST;
      cfg_q.cool_level     <= COOL_LEVEL_RST;
      cfg_q.preheat_end_s  <= PREHEAT_END_RST;
      cfg_q.soak_end_s     <= SOAK_END_RST;
      cfg_q.reflow_end_s   <= REFLOW_END_RST;
      cfg_q.warm_threshold <= WARM_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/rps_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first. The quotient
// shifts into the dividend register as the dividend bits shift out.
module rps_div
  import rps_pkg::*;
#(
  parameter int unsigned DIV_W = PROD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [SEC_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [SEC_W-1:0] rem_q, rem_d;
  logic [SEC_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [SEC_W:0]   shifted;
  logic [SEC_W+1:0] trial;
  logic             fits;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !trial[SEC_W+1];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? trial[SEC_W-1:0] : shifted[SEC_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/rps_dp.sv =====
module rps_dp
  import rps_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF,
  parameter int unsigned STAMP_BITS    = STAMP_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic              sw_i,
  input  logic [TEMP_W-1:0] temp_i,
  input  logic [NOW_W-1:0]  now_i,
  output res_t              res_o
);

  // Elapsed seconds use a rounded-up reciprocal of MS_PER_SECOND, exact for every
  // STAMP_BITS-wide difference. It is multiplied in one 16-bit slice per cycle.
  localparam int unsigned SL_W   = 16;
  localparam int unsigned SEC_SH = STAMP_BITS + $clog2(MS_PER_SECOND);
  localparam int unsigned SEC_PW = SEC_SH + 1;
  localparam int unsigned SEC_CH = (STAMP_BITS + SL_W) / SL_W;
  localparam int unsigned RCP_W  = SL_W * SEC_CH;
  localparam int unsigned ACC_W  = STAMP_BITS + RCP_W;
  localparam int unsigned SQ_W   = ACC_W - SEC_SH;
  localparam int unsigned SCNT_W = $clog2(SEC_CH);
  localparam logic [SEC_PW-1:0] SEC_POW = {1'b1, {SEC_SH{1'b0}}};
  localparam logic [SEC_PW-1:0] SEC_DIV = SEC_PW'(MS_PER_SECOND);
  localparam logic [RCP_W-1:0]  SEC_RCP = RCP_W'((SEC_POW + SEC_DIV - 1'b1) / SEC_DIV);

  // Item registers
  logic                  sw_q;
  logic [TEMP_W-1:0]     temp_q;
  logic [NOW_W-1:0]      now_q;

  // Profile state
  logic [STAMP_BITS-1:0] start_q;
  logic                  was_on_q;
  logic [TEMP_W-1:0]     target_q, target_d;
  logic                  fan_q, fan_d;

  // Ramp operands captured after the phase decision
  phase_e                phase_sel_q, phase_sel_d;
  logic                  ramp_q, ramp_d;
  logic [SEC_W-1:0]      num_q, num_d;
  logic [SEC_W-1:0]      span_q, span_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [TEMP_W-1:0]     from_q, from_d;

  res_t                  res_q, res_d;

  // Elapsed seconds unit
  logic [STAMP_BITS-1:0]      sec_x_q;
  logic [ACC_W-1:0]           sec_acc_q, sec_acc_d;
  logic [SCNT_W-1:0]          sec_cnt_q, sec_cnt_d;
  logic                       sec_busy_q, sec_busy_d;
  logic [SL_W-1:0]            sec_slice;
  logic [STAMP_BITS+SL_W-1:0] sec_part;
  logic [SQ_W-1:0]            sec_quo;
  logic [SEC_W-1:0]           elapsed;

  logic [STAMP_W_MAX-1:0] now_w;
  logic [STAMP_BITS-1:0]  now_s;
  logic [STAMP_BITS-1:0]  diff;
  logic                   first_tick;
  logic                   sec_start;
  logic                   ramp_start;
  logic                   div_busy;
  logic [PROD_W-1:0]      quotient;
  logic [PROD_W-1:0]      product;
  logic [DELTA_W-1:0]     delta;
  logic                   warm;
  logic [TEMP_W+1:0]      adj;
  logic [TEMP_W+1:0]      ramp_sum;

  assign now_w      = STAMP_W_MAX'(now_q);
  assign now_s      = now_w[STAMP_BITS-1:0];
  assign first_tick = sw_q && !was_on_q;
  // On the tick where the switch turns on, the start stamp equals now.
  assign diff       = first_tick ? '0 : (now_s - start_q);
  assign product    = PROD_W'(num_q) * PROD_W'(mag_q);
  assign sec_start  = cmd_i.div_start && !cmd_i.div_ramp;
  assign ramp_start = cmd_i.div_start && cmd_i.div_ramp;

  assign sec_slice = SEC_RCP[SL_W*sec_cnt_q +: SL_W];
  assign sec_part  = {{SL_W{1'b0}}, sec_x_q} * {{STAMP_BITS{1'b0}}, sec_slice};

  // Slices are taken from the top, so each step shifts the partial sum up one slice.
  always_comb begin
    sec_acc_d  = sec_acc_q;
    sec_cnt_d  = sec_cnt_q;
    sec_busy_d = sec_busy_q;
    if (sec_start) begin
      sec_acc_d  = '0;
      sec_cnt_d  = SCNT_W'(SEC_CH - 1);
      sec_busy_d = 1'b1;
    end else if (sec_busy_q) begin
      sec_acc_d = {sec_acc_q[ACC_W-SL_W-1:0], {SL_W{1'b0}}} + ACC_W'(sec_part);
      sec_cnt_d = sec_cnt_q - 1'b1;
      if (sec_cnt_q == '0) begin
        sec_busy_d = 1'b0;
      end
    end
  end

  // Counts past the widest boundary all select the same phase, so they saturate.
  assign sec_quo = sec_acc_q[ACC_W-1:SEC_SH];
  assign elapsed = (sec_quo > SQ_W'({SEC_W{1'b1}})) ? '1 : sec_quo[SEC_W-1:0];

  rps_div #(
    .DIV_W (PROD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ramp_start),
    .dividend_i (product),
    .divisor_i  (span_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign warm = $signed({temp_q[TEMP_W-1], temp_q}) >= $signed({2'b00, cfg_i.warm_threshold});

  // Phase decision from the elapsed seconds.
  always_comb begin
    phase_sel_d = phase_sel_q;
    ramp_d      = ramp_q;
    num_d       = num_q;
    span_d      = span_q;
    delta       = '0;
    from_d      = from_q;
    priority if (elapsed < cfg_i.preheat_end_s) begin
      phase_sel_d = PH_PREHEAT;
      ramp_d      = 1'b1;
      num_d       = elapsed;
      span_d      = cfg_i.preheat_end_s;
      delta       = {2'b00, cfg_i.preheat_target} - {temp_q[TEMP_W-1], temp_q};
      from_d      = temp_q;
    end else if (elapsed < cfg_i.soak_end_s) begin
      phase_sel_d = PH_SOAK;
      ramp_d      = 1'b0;
      from_d      = {1'b0, cfg_i.soak_level};
    end else if (elapsed < cfg_i.reflow_end_s) begin
      phase_sel_d = PH_REFLOW;
      ramp_d      = 1'b1;
      num_d       = elapsed - cfg_i.soak_end_s;
      span_d      = cfg_i.reflow_end_s - cfg_i.soak_end_s;
      delta       = {2'b00, cfg_i.peak_level} - {2'b00, cfg_i.soak_level};
      from_d      = {1'b0, cfg_i.soak_level};
    end else begin
      phase_sel_d = PH_COOL;
      ramp_d      = 1'b0;
      from_d      = {1'b0, cfg_i.cool_level};
    end
  end

  // The slope never reaches the most negative code, so its magnitude fits.
  assign neg_d = delta[DELTA_W-1];
  always_comb begin
    logic [DELTA_W-1:0] abs_delta;
    abs_delta = neg_d ? (~delta + 1'b1) : delta;
    mag_d     = abs_delta[MAG_W-1:0];
  end

  // Truncation toward zero: the magnitude was divided, the sign goes back on.
  assign adj      = neg_q ? (~{2'b00, quotient[MAG_W-1:0]} + 1'b1)
                          : {2'b00, quotient[MAG_W-1:0]};
  assign ramp_sum = {{2{from_q[TEMP_W-1]}}, from_q} + adj;

  always_comb begin
    target_d = target_q;
    fan_d    = fan_q;
    res_d    = res_q;
    if (sw_q) begin
      target_d = ramp_q ? ramp_sum[TEMP_W-1:0] : from_q;
      fan_d    = fan_q || (phase_sel_q == PH_COOL);
      res_d.setpoint      = target_d;
      res_d.phase         = phase_sel_q;
      res_d.heater_enable = 1'b1;
      res_d.fan_on        = fan_d;
      res_d.led_hot       = warm;
      res_d.led_cool      = (phase_sel_q == PH_COOL);
    end else begin
      fan_d = warm;
      res_d.setpoint      = target_q;
      res_d.phase         = warm ? PH_COOL : PH_WAIT;
      res_d.heater_enable = 1'b0;
      res_d.fan_on        = warm;
      res_d.led_hot       = 1'b0;
      res_d.led_cool      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sw_q   <= sw_i;
      temp_q <= temp_i;
      now_q  <= now_i;
    end
    if (sec_start) begin
      sec_x_q <= diff;
    end
    sec_acc_q <= sec_acc_d;
    if (cmd_i.select) begin
      phase_sel_q <= phase_sel_d;
      ramp_q      <= ramp_d;
      num_q       <= num_d;
      span_q      <= span_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      from_q      <= from_d;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      was_on_q   <= 1'b0;
      target_q   <= TARGET_RST;
      fan_q      <= 1'b0;
      sec_cnt_q  <= '0;
      sec_busy_q <= 1'b0;
    end else begin
      sec_cnt_q  <= sec_cnt_d;
      sec_busy_q <= sec_busy_d;
      if (cmd_i.latch_start) begin
        if (first_tick) begin
          start_q <= now_s;
        end
        was_on_q <= sw_q;
      end
      if (cmd_i.commit) begin
        target_q <= target_d;
        fan_q    <= fan_d;
      end
    end
  end

  assign status_o.sw_on    = sw_q;
  assign status_o.div_busy = div_busy || sec_busy_q;
  assign status_o.is_ramp  = ramp_d;
  assign res_o             = res_q;

endmodule

// ===== src/rps_ctrl.sv =====
`include "reflow_profile_sequencer_macros.svh"

module rps_ctrl
  import rps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  // The output slot is free when empty or when its transfer happens now.
  assign out_free = !m_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:        if (s_tvalid_i) state_d = ST_START;
      ST_START:       state_d = status_i.sw_on ? ST_DIV_ELAPSED : ST_FINISH;
      ST_DIV_ELAPSED: if (!status_i.div_busy) state_d = ST_SELECT;
      ST_SELECT:      state_d = status_i.is_ramp ? ST_MUL : ST_FINISH;
      ST_MUL:         state_d = ST_DIV_RAMP;
      ST_DIV_RAMP:    if (!status_i.div_busy) state_d = ST_FINISH;
      ST_FINISH:      if (out_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.load_in = s_tvalid_i;
      end
      ST_START: begin
        cmd_o.latch_start = 1'b1;
        cmd_o.div_start   = status_i.sw_on;
      end
      ST_SELECT: begin
        cmd_o.select = 1'b1;
      end
      ST_MUL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_ramp  = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.commit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.commit) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

  `RPS_ASSERT_SAME(a_commit_slot_free, cmd_o.commit, !m_valid_q || m_tready_i, "result written over a pending one")
  `RPS_ASSERT_NEXT(a_accept_starts, s_tvalid_i && s_tready_o, state_q == ST_START, "accepted item did not start")
  `RPS_ASSERT_SAME(a_div_start_idle, cmd_o.div_start, !status_i.div_busy, "divider restarted while busy")
  `RPS_ASSERT_NEXT(a_commit_valid, cmd_o.commit, m_valid_q && state_q == ST_IDLE, "commit did not present a result")

endmodule

// ===== src/reflow_profile_sequencer.sv =====
// With the switch off, an item goes straight to its result; in soak or cool-down the elapsed
// seconds are computed first, and on a ramp the ramp quotient is divided out after that.
// SEC_CH = (STAMP_BITS + 16) / 16 slices of reciprocal multiply give the elapsed seconds;
// a one-bit-per-cycle divider over PROD_W = 26 bits gives the ramp quotient.
// A new item is taken only once the result is registered, which can wait on m_axis_tready,
// so items do not overlap. Reset loads the register defaults and clears the state.
module reflow_profile_sequencer
  import rps_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF,
  parameter int unsigned STAMP_BITS    = STAMP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: switch_on [0], temperature [10:1], now_ms [42:11], zero [47:43]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tdata: setpoint [9:0], phase [12:10], heater_enable [13], fan_on [14],
  //        led_hot [15], led_cool [16], zero [23:17]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  res_t       res;

  rps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rps_dp #(
    .MS_PER_SECOND (MS_PER_SECOND),
    .STAMP_BITS    (STAMP_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .sw_i     (s_axis_tdata[0]),
    .temp_i   (s_axis_tdata[TEMP_W:1]),
    .now_i    (s_axis_tdata[TEMP_W+NOW_W:TEMP_W+1]),
    .res_o    (res)
  );

  assign m_axis_tdata = M_DATA_W'(res);

endmodule
